// ===== hw/rtl/dmr_pkg.sv =====
// ---------------------------------------------------------------------------
// dmr_pkg: shared types and constants for the dual motor ramp core
// Duty is carried in 1/20 percent units, times in milliseconds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmr_pkg;

    localparam int PCT_W      = 7;
    localparam int DUTY_W     = 11;
    localparam int MS_W       = 16;
    localparam int TICK_W     = 10;
    localparam int NUM_W      = DUTY_W + MS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
    localparam logic [DUTY_W-1:0] DEAD_BAND = 11'd10;

    // vehicle modes
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_RUN     = 2'd1;
    localparam logic [1:0] MODE_LIMITED = 2'd2;
    localparam logic [1:0] MODE_DECEL   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RUN_CAP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITED_CAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_LOST_CAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MOVE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_RAMP_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BRAKE_MS = 3'd6;

    typedef enum logic [1:0] {SGN_NONE, SGN_FWD, SGN_REV} t_sign;
    typedef enum logic [1:0] {BR_COAST, BR_FWD, BR_REV, BR_SHORT} t_bridge;
    typedef enum logic [1:0] {PH_IDLE, PH_RAMP, PH_BRAKE, PH_DONE} t_phase;

    typedef enum logic [2:0] {
        LOP_NONE,
        LOP_SLEW,
        LOP_RAMP,
        LOP_BRAKE,
        LOP_CLEAR
    } t_lane_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MAP,
        ST_DIV,
        ST_COMMIT,
        ST_OUT
    } t_state;

    // sequencer to lane
    typedef struct packed {
        logic     map1;
        logic     map2;
        t_lane_op op;
    } t_lane_ctl;

    // lane to merge stage
    typedef struct packed {
        t_bridge           bridge;
        t_sign             sign;
        logic [PCT_W-1:0]  pwm;
        logic [PCT_W-1:0]  status_duty;
        logic [DUTY_W-1:0] duty;
    } t_lane_stat;

    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [1:0]        vehicle_mode;
        logic              link_lost;
        logic signed [7:0] left_setpoint;
        logic signed [7:0] right_setpoint;
    } t_in_item;

    typedef struct packed {
        logic             standby_enable;
        logic [1:0]       left_bridge;
        logic [PCT_W-1:0] left_pwm;
        logic [1:0]       right_bridge;
        logic [PCT_W-1:0] right_pwm;
        logic [PCT_W-1:0] speed_cap;
        logic [PCT_W-1:0] left_status_duty;
        logic             left_reverse;
        logic [PCT_W-1:0] right_status_duty;
        logic             right_reverse;
        logic             stop_complete;
    } t_out_item;

    // percent values above full scale act as full scale
    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_FULL) ? PCT_FULL : v;
    endfunction

endpackage

// ===== hw/rtl/dmr_div.sv =====
// ---------------------------------------------------------------------------
// dmr_div: radix-2 restoring divider for the safe stop ramp
// One quotient bit per cycle. The dividend is known to give a quotient
// that fits the duty width, so the upper half starts below the divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmr_div import dmr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [MS_W-1:0]   i_den,
    output logic              o_busy,
    output logic [DUTY_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DUTY_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [MS_W-1:0]   r_rem;
    logic [DUTY_W-1:0] r_quo;

    logic [MS_W:0]     w_trial;
    logic              w_ge;
    logic [MS_W-1:0]   w_rem_n;

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_quo[DUTY_W-1]};
        w_ge    = (w_trial >= {1'b0, i_den});
        w_rem_n = w_ge ? MS_W'(w_trial - {1'b0, i_den}) : w_trial[MS_W-1:0];
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DUTY_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:DUTY_W];
            r_quo <= i_num[DUTY_W-1:0];
        end else if (o_busy) begin
            r_rem <= w_rem_n;
            r_quo <= {r_quo[DUTY_W-2:0], w_ge};
        end
    end

endmodule

// ===== hw/rtl/dmr_lane.sv =====
// ---------------------------------------------------------------------------
// dmr_lane: one motor channel
// Setpoint mapping pipeline, slew limiter, dead band, stored duty, sign
// and held bridge mode. Both channels run the same commands side by side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmr_lane import dmr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic signed [7:0] i_setpoint,
    input  logic [PCT_W-1:0]  i_cap,
    input  logic [PCT_W-1:0]  i_min_move,
    input  logic [DUTY_W-1:0] i_ramp_step,
    input  logic [DUTY_W-1:0] i_ramp_duty,
    output t_lane_stat        o_stat
);

    // x/5 = (x * 52429) >> 18 for x up to 10000
    localparam logic [29:0] RECIP5  = 30'd52429;
    // x/20 = (x * 3277) >> 16 for x below 2048
    localparam logic [22:0] RECIP20 = 23'd3277;

    // channel state
    logic [DUTY_W-1:0] r_duty;
    t_sign             r_sign;
    t_bridge           r_bridge;

    // mapping pipeline
    logic [13:0]        r_prod;
    logic               r_nz;
    logic               r_neg;
    logic [PCT_W-1:0]   r_mm;
    logic signed [12:0] r_target;

    logic [7:0]         w_mag;
    logic [PCT_W-1:0]   w_mag_cap;
    logic [PCT_W-1:0]   w_mm;
    logic [PCT_W-1:0]   w_span;
    logic [29:0]        w_q_full;
    logic [DUTY_W-1:0]  w_mapped;

    logic signed [12:0] w_cur;
    logic signed [13:0] w_delta;
    logic signed [13:0] w_step;
    logic signed [13:0] w_dclamp;
    logic signed [13:0] w_next;
    logic signed [13:0] w_db;
    logic [DUTY_W-1:0]  w_next_abs;
    logic               w_ramp_on;
    logic [22:0]        w_div20;

    // stage 1: magnitude, cap, span product
    always_comb begin
        w_mag     = i_setpoint[7] ? 8'(-i_setpoint) : 8'(i_setpoint);
        w_mag_cap = (w_mag > {1'b0, i_cap}) ? i_cap : w_mag[PCT_W-1:0];
        w_mm      = clamp_pct(i_min_move);
        w_span    = PCT_FULL - w_mm;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.map1) begin
            r_prod <= 14'(w_mag_cap) * 14'(w_span);
            r_nz   <= (w_mag_cap != '0);
            r_neg  <= i_setpoint[7];
            r_mm   <= w_mm;
        end
    end

    // stage 2: divide by five, add the minimum moving duty
    always_comb begin
        w_q_full = 30'(r_prod) * RECIP5;
        w_mapped = 11'({r_mm, 4'b0000}) + 11'({r_mm, 2'b00}) + DUTY_W'(w_q_full >> 18);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.map2) begin
            if (!r_nz) begin
                r_target <= '0;
            end else if (r_neg) begin
                r_target <= -$signed({2'b00, w_mapped});
            end else begin
                r_target <= $signed({2'b00, w_mapped});
            end
        end
    end

    // slew limiter
    always_comb begin
        case (r_sign)
            SGN_FWD: w_cur = $signed({2'b00, r_duty});
            SGN_REV: w_cur = -$signed({2'b00, r_duty});
            default: w_cur = '0;
        endcase
        w_step  = $signed({3'b000, i_ramp_step});
        w_db    = $signed({3'b000, DEAD_BAND});
        w_delta = 14'(r_target) - 14'(w_cur);
        if (w_delta > w_step) begin
            w_dclamp = w_step;
        end else if (w_delta < -w_step) begin
            w_dclamp = -w_step;
        end else begin
            w_dclamp = w_delta;
        end
        w_next     = 14'(w_cur) + w_dclamp;
        w_next_abs = w_next[13] ? DUTY_W'(-w_next) : DUTY_W'(w_next);
        // stop ramp keeps the direction unless it falls into the dead band
        w_ramp_on  = (i_ramp_duty > DEAD_BAND) && (r_sign == SGN_FWD || r_sign == SGN_REV);
    end

    // duty, sign and bridge update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty   <= '0;
            r_sign   <= SGN_NONE;
            r_bridge <= BR_COAST;
        end else begin
            case (i_ctl.op)
                LOP_SLEW: begin
                    r_duty <= w_next_abs;
                    if (w_next > w_db) begin
                        r_sign   <= SGN_FWD;
                        r_bridge <= BR_FWD;
                    end else if (w_next < -w_db) begin
                        r_sign   <= SGN_REV;
                        r_bridge <= BR_REV;
                    end else begin
                        r_sign   <= SGN_NONE;
                        r_bridge <= BR_COAST;
                    end
                end
                LOP_RAMP: begin
                    r_duty <= i_ramp_duty;
                    if (w_ramp_on) begin
                        r_bridge <= (r_sign == SGN_FWD) ? BR_FWD : BR_REV;
                    end else begin
                        r_sign   <= SGN_NONE;
                        r_bridge <= BR_COAST;
                    end
                end
                LOP_BRAKE: begin
                    r_bridge <= BR_SHORT;
                end
                LOP_CLEAR: begin
                    r_duty   <= '0;
                    r_sign   <= SGN_NONE;
                    r_bridge <= BR_COAST;
                end
                default: begin
                end
            endcase
        end
    end

    // status: duty in whole percent; PWM is live only while driving
    always_comb begin
        w_div20            = 23'(r_duty) * RECIP20;
        o_stat.duty        = r_duty;
        o_stat.sign        = r_sign;
        o_stat.bridge      = r_bridge;
        o_stat.status_duty = w_div20[22:16];
        o_stat.pwm         = (r_bridge == BR_FWD || r_bridge == BR_REV) ? w_div20[22:16] : '0;
    end

endmodule

// ===== hw/rtl/dual_motor_ramp_and_safe_stop_core.sv =====
// ---------------------------------------------------------------------------
// dual_motor_ramp_and_safe_stop_core: two-channel slew limited motor drive
// Each item runs through the prepare, map, commit and output states, with a
// divide state between map and commit on safe stop ramp ticks (the 11-bit
// radix-2 divider). A new item is taken only once the last result is loaded
// into the output register; the pace is set by the item sequencer and the shared divider.
// Reset: duties zero, bridges coast, standby off, stop idle, registers at
// defaults; no clearing pass, the block takes items right after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_motor_ramp_and_safe_stop_core import dmr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [PCT_W-1:0]  r_run_cap;
    logic [PCT_W-1:0]  r_limited_cap;
    logic [PCT_W-1:0]  r_link_cap;
    logic [PCT_W-1:0]  r_min_move;
    logic [DUTY_W-1:0] r_ramp_step;
    logic [MS_W-1:0]   r_ramp_ms;
    logic [MS_W-1:0]   r_brake_ms;

    // sequencer and stop state
    t_state            r_state;
    t_state            n_state;
    t_phase            r_phase;
    logic [MS_W-1:0]   r_elapsed;
    logic [DUTY_W-1:0] r_start_duty;
    logic              r_standby;

    // item registers
    t_in_item          r_item;
    logic [PCT_W-1:0]  r_cap;
    logic [MS_W-1:0]   r_el_sum;
    logic              r_el_lt;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [PCT_W-1:0]  w_cap;
    logic              w_accept;
    logic              w_is_decel;
    logic              w_drive;
    logic [MS_W:0]     w_el_add;
    logic [MS_W-1:0]   w_el_sat;
    logic [MS_W-1:0]   w_ramp_left;
    logic [NUM_W-1:0]  w_num;
    logic              w_el_lt;
    logic              w_go_div;
    logic              w_brake_end;
    logic [PCT_W-1:0]  w_lane_cap;
    logic [DUTY_W-1:0] w_ramp_duty;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_div_start;
    logic              w_div_busy;
    logic [DUTY_W-1:0] w_div_quot;
    t_lane_ctl         w_lane_ctl;
    t_lane_stat        w_left;
    t_lane_stat        w_right;

    // speed cap for the incoming item
    always_comb begin
        if (i_in_item.link_lost) begin
            w_cap = clamp_pct(r_link_cap);
        end else begin
            case (i_in_item.vehicle_mode)
                MODE_RUN:     w_cap = clamp_pct(r_run_cap);
                MODE_LIMITED: w_cap = clamp_pct(r_limited_cap);
                default:      w_cap = '0;
            endcase
        end
    end

    // stop timing and ramp numerator
    always_comb begin
        w_accept    = i_in_valid && !o_in_stall;
        w_is_decel  = (r_item.vehicle_mode == MODE_DECEL);
        w_drive     = (r_item.vehicle_mode == MODE_RUN) || (r_item.vehicle_mode == MODE_LIMITED);
        w_el_add    = {1'b0, r_elapsed} + (MS_W+1)'(r_item.tick_ms);
        w_el_sat    = w_el_add[MS_W] ? '1 : w_el_add[MS_W-1:0];
        w_ramp_left = r_ramp_ms - r_el_sum;
        w_num       = NUM_W'(r_start_duty) * NUM_W'(w_ramp_left);
        w_el_lt     = (r_el_sum < r_ramp_ms);
        w_go_div    = w_is_decel && (r_phase == PH_RAMP) && w_el_lt;
        w_brake_end = (r_el_sum >= r_brake_ms);
        w_lane_cap  = w_drive ? r_cap : '0;
        w_ramp_duty = r_el_lt ? w_div_quot : '0;
        w_out_free  = !r_out_valid || !i_out_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_PREP;
            ST_PREP:   n_state = ST_MAP;
            ST_MAP:    n_state = w_go_div ? ST_DIV : ST_COMMIT;
            ST_DIV:    if (!w_div_busy) n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_OUT;
            ST_OUT:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall      = (r_state != ST_IDLE);
        w_lane_ctl.map1 = (r_state == ST_PREP);
        w_lane_ctl.map2 = (r_state == ST_MAP);
        w_lane_ctl.op   = LOP_NONE;
        w_div_start     = (r_state == ST_MAP) && w_go_div;
        w_out_load      = (r_state == ST_OUT) && w_out_free;
        if (r_state == ST_COMMIT) begin
            if (!w_is_decel) begin
                w_lane_ctl.op = LOP_SLEW;
            end else begin
                case (r_phase)
                    PH_RAMP:  w_lane_ctl.op = LOP_RAMP;
                    PH_BRAKE: w_lane_ctl.op = w_brake_end ? LOP_CLEAR : LOP_BRAKE;
                    default:  w_lane_ctl.op = LOP_NONE;
                endcase
            end
        end
    end

    // channel lanes
    dmr_lane u_lane_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_lane_ctl),
        .i_setpoint  (r_item.left_setpoint),
        .i_cap       (w_lane_cap),
        .i_min_move  (r_min_move),
        .i_ramp_step (r_ramp_step),
        .i_ramp_duty (w_ramp_duty),
        .o_stat      (w_left)
    );

    dmr_lane u_lane_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_lane_ctl),
        .i_setpoint  (r_item.right_setpoint),
        .i_cap       (w_lane_cap),
        .i_min_move  (r_min_move),
        .i_ramp_step (r_ramp_step),
        .i_ramp_duty (w_ramp_duty),
        .o_stat      (w_right)
    );

    // shared stop ramp divider
    dmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_ramp_ms),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    // control registers, configuration and stop sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_run_cap     <= 7'd100;
            r_limited_cap <= 7'd80;
            r_link_cap    <= 7'd30;
            r_min_move    <= 7'd25;
            r_ramp_step   <= 11'd8;
            r_ramp_ms     <= 16'd1500;
            r_brake_ms    <= 16'd500;
            r_phase       <= PH_IDLE;
            r_elapsed     <= '0;
            r_standby     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RUN_CAP:       r_run_cap     <= i_cfg_data[PCT_W-1:0];
                    REG_LIMITED_CAP:   r_limited_cap <= i_cfg_data[PCT_W-1:0];
                    REG_LINK_LOST_CAP: r_link_cap    <= i_cfg_data[PCT_W-1:0];
                    REG_MIN_MOVE:      r_min_move    <= i_cfg_data[PCT_W-1:0];
                    REG_RAMP_STEP:     r_ramp_step   <= i_cfg_data[DUTY_W-1:0];
                    REG_STOP_RAMP_MS:  r_ramp_ms     <= i_cfg_data[MS_W-1:0];
                    REG_STOP_BRAKE_MS: r_brake_ms    <= i_cfg_data[MS_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == ST_COMMIT) begin
                if (w_is_decel) begin
                    r_standby <= 1'b1;
                    case (r_phase)
                        PH_IDLE: begin
                            r_phase   <= PH_RAMP;
                            r_elapsed <= '0;
                        end
                        PH_RAMP: begin
                            if (r_el_lt) begin
                                r_elapsed <= r_el_sum;
                            end else begin
                                r_phase   <= PH_BRAKE;
                                r_elapsed <= '0;
                            end
                        end
                        PH_BRAKE: begin
                            r_elapsed <= r_el_sum;
                            if (w_brake_end) begin
                                r_standby <= 1'b0;
                                r_phase   <= PH_DONE;
                            end
                        end
                        default: r_elapsed <= r_el_sum;
                    endcase
                end else begin
                    r_phase   <= PH_IDLE;
                    r_elapsed <= '0;
                    r_standby <= w_drive;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
            r_cap  <= w_cap;
        end
        if (r_state == ST_PREP) begin
            r_el_sum <= w_el_sat;
        end
        if (r_state == ST_MAP) begin
            r_el_lt <= w_el_lt;
        end
        // stop entry captures the larger stored duty
        if (r_state == ST_COMMIT && w_is_decel && r_phase == PH_IDLE) begin
            r_start_duty <= (w_left.duty > w_right.duty) ? w_left.duty : w_right.duty;
        end
    end

    // merge both lanes into the result item
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.standby_enable    <= r_standby;
            r_out.left_bridge       <= w_left.bridge;
            r_out.left_pwm          <= w_left.pwm;
            r_out.right_bridge      <= w_right.bridge;
            r_out.right_pwm         <= w_right.pwm;
            r_out.speed_cap         <= r_cap;
            r_out.left_status_duty  <= w_left.status_duty;
            r_out.left_reverse      <= (w_left.sign == SGN_REV);
            r_out.right_status_duty <= w_right.status_duty;
            r_out.right_reverse     <= (w_right.sign == SGN_REV);
            r_out.stop_complete     <= (r_phase == PH_DONE);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // divider only runs while the sequencer waits on it
    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == ST_DIV))
        else $error("divider busy outside the divide state");

    // a finished stop leaves both channels coasting with no stored duty
    a_done_is_coast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (w_left.bridge == BR_COAST && w_right.bridge == BR_COAST
                                  && w_left.duty == '0 && w_right.duty == '0))
        else $error("stop done with a channel still driven");

    // an accepted item always starts the mapping pipeline
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_PREP))
        else $error("accepted item did not enter the pipeline");

    // a new result appears only out of the output state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside the output state");

endmodule
